/* rtl/lpp_pkg.sv */
// lpp_pkg: shared types, constants and helpers of the lattice predator-prey block
// depends on nothing; imported by every module of the block but lpp_ram
`default_nettype none

package lpp_pkg;

   localparam int SIDE_W     = 7;
   localparam int GRID_SIDE  = 1 << SIDE_W;
   localparam int ADDR_W     = 2 * SIDE_W;
   localparam int CELLS      = GRID_SIDE * GRID_SIDE;
   localparam int CELL_W     = 2;
   localparam int TALLY_W    = 15;
   localparam int CHANCE_W   = 17;
   localparam int DRAW_W     = 16;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CELL_W-1:0] {
      CELL_EMPTY = 2'd0,
      CELL_FISH  = 2'd1,
      CELL_SHARK = 2'd2
   } cell_type;

   typedef enum logic [1:0] {
      MODE_SEED   = 2'd0,
      MODE_UPDATE = 2'd1,
      MODE_SWAP   = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      REG_FISH_BIRTH   = 3'd0,
      REG_SHARK_STAY   = 3'd1,
      REG_SHARK_STARVE = 3'd2,
      REG_SEED_FISH    = 3'd3,
      REG_SEED_SHARK   = 3'd4
   } reg_index_type;

   localparam logic [CHANCE_W-1:0] RST_FISH_BIRTH   = 17'd32768;
   localparam logic [CHANCE_W-1:0] RST_SHARK_STAY   = 17'd3277;
   localparam logic [CHANCE_W-1:0] RST_SHARK_STARVE = 17'd62259;
   localparam logic [CHANCE_W-1:0] RST_SEED_FISH    = 17'd26214;
   localparam logic [CHANCE_W-1:0] RST_SEED_SHARK   = 17'd58982;

   typedef struct packed {
      logic [CHANCE_W-1:0] fish_birth;
      logic [CHANCE_W-1:0] shark_stay;
      logic [CHANCE_W-1:0] shark_starve;
      logic [CHANCE_W-1:0] seed_fish;
      logic [CHANCE_W-1:0] seed_shark;
   } cfg_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [CELL_W-1:0] wdata;
   } mem_req_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_NB,
      ST_RD_LAST,
      ST_CALC,
      ST_WR1,
      ST_WR2,
      ST_DONE
   } state_type;

   // torus neighbour: 0 row+1, 1 col+1, 2 row-1, 3 col-1
   function automatic logic [ADDR_W-1:0] nb_addr(input logic [SIDE_W-1:0] row,
                                                 input logic [SIDE_W-1:0] col,
                                                 input logic [1:0] dir);
      logic [SIDE_W-1:0] nr;
      logic [SIDE_W-1:0] nc;
      nr = row;
      nc = col;
      case (dir)
         2'd0:    nr = row + SIDE_W'(1);
         2'd1:    nc = col + SIDE_W'(1);
         2'd2:    nr = row - SIDE_W'(1);
         default: nc = col - SIDE_W'(1);
      endcase
      return {nr, nc};
   endfunction

endpackage

`default_nettype wire

/* rtl/lattice_predator_prey_update.sv */
// lattice_predator_prey_update: top level of the fish/shark torus block
// depends on lpp_pkg, lpp_csr, lpp_engine and lpp_ram
`default_nettype none

// Fish/shark predator-prey lattice on a 128 x 128 torus held in one single-port
// grid ram, with running fish and shark counts. Each req transaction is one
// event (seed, update or swap) and yields exactly one rsp transaction with the
// counts and the chosen site afterwards. After reset the block clears the grid,
// one cell a cycle, with req_ready low; csr writes are taken throughout. An
// event then runs from acceptance to a result ready in the output register:
// the site and all four neighbours are read one per cycle through the single
// ram port, one state decides, and one or two states write back. A new event
// is accepted while an earlier result waits.
module lattice_predator_prey_update (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [lpp_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [lpp_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [lpp_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                pready,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [1:0]                     req_mode,
   input  wire logic [lpp_pkg::SIDE_W-1:0]     req_site_row,
   input  wire logic [lpp_pkg::SIDE_W-1:0]     req_site_col,
   input  wire logic [1:0]                     req_direction,
   input  wire logic [lpp_pkg::DRAW_W-1:0]     req_pick_draw,
   input  wire logic [lpp_pkg::DRAW_W-1:0]     req_chance_draw,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [lpp_pkg::TALLY_W-1:0]    rsp_fish_total,
   output logic      [lpp_pkg::TALLY_W-1:0]    rsp_shark_total,
   output logic      [lpp_pkg::CELL_W-1:0]     rsp_site_after
);
   import lpp_pkg::*;

   cfg_type           cfg;
   mem_req_type       mem_req;
   logic [CELL_W-1:0] mem_rdata;

   lpp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lpp_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_site_row    (req_site_row),
      .req_site_col    (req_site_col),
      .req_direction   (req_direction),
      .req_pick_draw   (req_pick_draw),
      .req_chance_draw (req_chance_draw),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_fish_total  (rsp_fish_total),
      .rsp_shark_total (rsp_shark_total),
      .rsp_site_after  (rsp_site_after),
      .mem_req         (mem_req),
      .mem_rdata       (mem_rdata)
   );

   lpp_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_grid (
      .clock (clock),
      .we    (mem_req.we),
      .addr  (mem_req.addr),
      .wdata (mem_req.wdata),
      .rdata (mem_rdata)
   );

endmodule

`default_nettype wire

/* rtl/lpp_ram.sv */
// lpp_ram: generic single-port synchronous ram with registered read
// no dependencies
`default_nettype none

module lpp_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end

endmodule

`default_nettype wire

/* rtl/lpp_csr.sv */
// lpp_csr: apb-style configuration registers (chances and seeding thresholds)
// depends on lpp_pkg
`default_nettype none

module lpp_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [lpp_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [lpp_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [lpp_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                  pready,
   output lpp_pkg::cfg_type                      cfg
);
   import lpp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic [2:0] idx;
   logic wr;

   assign idx    = paddr[CSR_ADDR_W-1:2];
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_FISH_BIRTH:   cfg_in.fish_birth   = pwdata[CHANCE_W-1:0];
            REG_SHARK_STAY:   cfg_in.shark_stay   = pwdata[CHANCE_W-1:0];
            REG_SHARK_STARVE: cfg_in.shark_starve = pwdata[CHANCE_W-1:0];
            REG_SEED_FISH:    cfg_in.seed_fish    = pwdata[CHANCE_W-1:0];
            REG_SEED_SHARK:   cfg_in.seed_shark   = pwdata[CHANCE_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_FISH_BIRTH:   prdata = CSR_DATA_W'(cfg_ff.fish_birth);
         REG_SHARK_STAY:   prdata = CSR_DATA_W'(cfg_ff.shark_stay);
         REG_SHARK_STARVE: prdata = CSR_DATA_W'(cfg_ff.shark_starve);
         REG_SEED_FISH:    prdata = CSR_DATA_W'(cfg_ff.seed_fish);
         REG_SEED_SHARK:   prdata = CSR_DATA_W'(cfg_ff.seed_shark);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fish_birth   <= RST_FISH_BIRTH;
         cfg_ff.shark_stay   <= RST_SHARK_STAY;
         cfg_ff.shark_starve <= RST_SHARK_STARVE;
         cfg_ff.seed_fish    <= RST_SEED_FISH;
         cfg_ff.seed_shark   <= RST_SEED_SHARK;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/lpp_engine.sv */
// lpp_engine: event sequencer; clears the grid, reads site and neighbours,
// decides the update, writes back, keeps the tallies and the result register
// depends on lpp_pkg; drives one lpp_ram port
`default_nettype none

module lpp_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lpp_pkg::cfg_type              cfg,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_mode,
   input  wire logic [lpp_pkg::SIDE_W-1:0]    req_site_row,
   input  wire logic [lpp_pkg::SIDE_W-1:0]    req_site_col,
   input  wire logic [1:0]                    req_direction,
   input  wire logic [lpp_pkg::DRAW_W-1:0]    req_pick_draw,
   input  wire logic [lpp_pkg::DRAW_W-1:0]    req_chance_draw,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [lpp_pkg::TALLY_W-1:0]   rsp_fish_total,
   output logic      [lpp_pkg::TALLY_W-1:0]   rsp_shark_total,
   output logic      [lpp_pkg::CELL_W-1:0]    rsp_site_after,
   output lpp_pkg::mem_req_type               mem_req,
   input  wire logic [lpp_pkg::CELL_W-1:0]    mem_rdata
);
   import lpp_pkg::*;

   state_type state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [1:0] k_ff, k_in;

   logic [1:0]        mode_ff, mode_in;
   logic [SIDE_W-1:0] row_ff, row_in;
   logic [SIDE_W-1:0] col_ff, col_in;
   logic [1:0]        dir_ff, dir_in;
   logic [DRAW_W-1:0] pick_ff, pick_in;
   logic [DRAW_W-1:0] draw_ff, draw_in;

   cell_type site_cell_ff, site_cell_in;
   cell_type nb_cell_ff [4];
   cell_type nb_cell_in [4];

   // write plan: two slots, each with old value for the tallies
   logic              w1_en_ff, w1_en_in, w2_en_ff, w2_en_in;
   logic              w1_cnt_ff, w1_cnt_in, w2_cnt_ff, w2_cnt_in;
   logic [ADDR_W-1:0] w1_addr_ff, w1_addr_in, w2_addr_ff, w2_addr_in;
   cell_type          w1_val_ff, w1_val_in, w2_val_ff, w2_val_in;
   cell_type          w1_old_ff, w1_old_in, w2_old_ff, w2_old_in;
   cell_type          after_ff, after_in;

   logic [TALLY_W-1:0] fish_ff, fish_in, shark_ff, shark_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [TALLY_W-1:0] rsp_fish_ff, rsp_fish_in, rsp_shark_ff, rsp_shark_in;
   logic [CELL_W-1:0]  rsp_site_ff, rsp_site_in;

   logic accept;

   assign accept          = req_valid && req_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_fish_total  = rsp_fish_ff;
   assign rsp_shark_total = rsp_shark_ff;
   assign rsp_site_after  = rsp_site_ff;

   always_comb begin
      logic [ADDR_W-1:0] site_a;
      logic [ADDR_W-1:0] nb_a;
      logic [2:0]        fcount;
      logic [2:0]        pre;
      logic [18:0]       prod;
      logic [2:0]        sel;
      logic [1:0]        prey_dir;
      logic              cur_cnt;
      cell_type          cur_old;
      cell_type          cur_new;
      cell_type          seed_v;
      logic [DRAW_W:0]   draw_x;

      state_in     = state_ff;
      clr_in       = clr_ff;
      k_in         = k_ff;
      mode_in      = mode_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      dir_in       = dir_ff;
      pick_in      = pick_ff;
      draw_in      = draw_ff;
      site_cell_in = site_cell_ff;
      nb_cell_in   = nb_cell_ff;
      w1_en_in     = w1_en_ff;
      w1_cnt_in    = w1_cnt_ff;
      w1_addr_in   = w1_addr_ff;
      w1_val_in    = w1_val_ff;
      w1_old_in    = w1_old_ff;
      w2_en_in     = w2_en_ff;
      w2_cnt_in    = w2_cnt_ff;
      w2_addr_in   = w2_addr_ff;
      w2_val_in    = w2_val_ff;
      w2_old_in    = w2_old_ff;
      after_in     = after_ff;
      fish_in      = fish_ff;
      shark_in     = shark_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_fish_in  = rsp_fish_ff;
      rsp_shark_in = rsp_shark_ff;
      rsp_site_in  = rsp_site_ff;
      req_ready    = 1'b0;
      mem_req.we    = 1'b0;
      mem_req.addr  = {req_site_row, req_site_col};
      mem_req.wdata = CELL_EMPTY;

      site_a = {row_ff, col_ff};
      nb_a   = nb_addr(row_ff, col_ff, dir_ff);
      draw_x = {1'b0, draw_ff};

      fcount = '0;
      for (int k = 0; k < 4; k++) begin
         if (nb_cell_ff[k] == CELL_FISH) begin
            fcount = fcount + 3'd1;
         end
      end
      prod = 19'(fcount) * 19'(pick_ff);
      sel  = prod[18:16];
      pre      = '0;
      prey_dir = '0;
      for (int k = 0; k < 4; k++) begin
         if (nb_cell_ff[k] == CELL_FISH) begin
            if (pre == sel) begin
               prey_dir = 2'(k);
            end
            pre = pre + 3'd1;
         end
      end

      if (draw_x < cfg.seed_fish) begin
         seed_v = CELL_FISH;
      end else if (draw_x >= cfg.seed_shark) begin
         seed_v = CELL_SHARK;
      end else begin
         seed_v = CELL_EMPTY;
      end

      // active write slot for the tally update
      if (state_ff == ST_WR2) begin
         cur_cnt = w2_cnt_ff;
         cur_old = w2_old_ff;
         cur_new = w2_val_ff;
      end else begin
         cur_cnt = w1_cnt_ff;
         cur_old = w1_old_ff;
         cur_new = w1_val_ff;
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = clr_ff;
            mem_req.wdata = CELL_EMPTY;
            clr_in        = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mode_in  = req_mode;
               row_in   = req_site_row;
               col_in   = req_site_col;
               dir_in   = req_direction;
               pick_in  = req_pick_draw;
               draw_in  = req_chance_draw;
               k_in     = '0;
               state_in = ST_RD_NB;
            end
         end
         ST_RD_NB: begin
            mem_req.addr = nb_addr(row_ff, col_ff, k_ff);
            if (k_ff == 2'd0) begin
               site_cell_in = cell_type'(mem_rdata);
            end else begin
               nb_cell_in[k_ff - 2'd1] = cell_type'(mem_rdata);
            end
            k_in = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               state_in = ST_RD_LAST;
            end
         end
         ST_RD_LAST: begin
            nb_cell_in[3] = cell_type'(mem_rdata);
            state_in      = ST_CALC;
         end
         ST_CALC: begin
            w1_en_in   = 1'b0;
            w2_en_in   = 1'b0;
            w1_cnt_in  = 1'b1;
            w2_cnt_in  = 1'b1;
            w1_addr_in = site_a;
            w2_addr_in = site_a;
            w1_val_in  = CELL_EMPTY;
            w2_val_in  = CELL_EMPTY;
            w1_old_in  = site_cell_ff;
            w2_old_in  = site_cell_ff;
            after_in   = site_cell_ff;
            case (mode_ff)
               MODE_SEED: begin
                  w1_en_in  = 1'b1;
                  w1_val_in = seed_v;
                  after_in  = seed_v;
               end
               MODE_UPDATE: begin
                  if (site_cell_ff == CELL_FISH) begin
                     if (nb_cell_ff[dir_ff] == CELL_EMPTY && draw_x < cfg.fish_birth) begin
                        w1_en_in   = 1'b1;
                        w1_addr_in = nb_a;
                        w1_val_in  = CELL_FISH;
                        w1_old_in  = CELL_EMPTY;
                     end
                  end else if (site_cell_ff == CELL_SHARK) begin
                     if (fcount != 3'd0) begin
                        w1_en_in   = 1'b1;
                        w1_addr_in = nb_addr(row_ff, col_ff, prey_dir);
                        w1_val_in  = CELL_SHARK;
                        w1_old_in  = CELL_FISH;
                        if (draw_x >= cfg.shark_stay) begin
                           w2_en_in = 1'b1;
                           after_in = CELL_EMPTY;
                        end
                     end else if (draw_x < cfg.shark_starve) begin
                        w1_en_in = 1'b1;
                        after_in = CELL_EMPTY;
                     end
                  end
               end
               MODE_SWAP: begin
                  w1_en_in   = 1'b1;
                  w1_cnt_in  = 1'b0;
                  w1_val_in  = nb_cell_ff[dir_ff];
                  w2_en_in   = 1'b1;
                  w2_cnt_in  = 1'b0;
                  w2_addr_in = nb_a;
                  w2_val_in  = site_cell_ff;
                  after_in   = nb_cell_ff[dir_ff];
               end
               default: begin
                  after_in = site_cell_ff;
               end
            endcase
            state_in = ST_WR1;
         end
         ST_WR1, ST_WR2: begin
            if (state_ff == ST_WR2) begin
               mem_req.we    = w2_en_ff;
               mem_req.addr  = w2_addr_ff;
               mem_req.wdata = w2_val_ff;
            end else begin
               mem_req.we    = w1_en_ff;
               mem_req.addr  = w1_addr_ff;
               mem_req.wdata = w1_val_ff;
            end
            if (mem_req.we && cur_cnt) begin
               fish_in  = fish_ff - TALLY_W'(cur_old == CELL_FISH)
                                  + TALLY_W'(cur_new == CELL_FISH);
               shark_in = shark_ff - TALLY_W'(cur_old == CELL_SHARK)
                                   + TALLY_W'(cur_new == CELL_SHARK);
            end
            if (state_ff == ST_WR1 && w2_en_ff) begin
               state_in = ST_WR2;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_fish_in  = fish_ff;
               rsp_shark_in = shark_ff;
               rsp_site_in  = after_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // result leaves on its own handshake
      if (rsp_valid_ff && rsp_ready && !(state_ff == ST_DONE)) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         k_ff         <= '0;
         fish_ff      <= '0;
         shark_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         k_ff         <= k_in;
         fish_ff      <= fish_in;
         shark_ff     <= shark_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      dir_ff       <= dir_in;
      pick_ff      <= pick_in;
      draw_ff      <= draw_in;
      site_cell_ff <= site_cell_in;
      nb_cell_ff   <= nb_cell_in;
      w1_en_ff     <= w1_en_in;
      w1_cnt_ff    <= w1_cnt_in;
      w1_addr_ff   <= w1_addr_in;
      w1_val_ff    <= w1_val_in;
      w1_old_ff    <= w1_old_in;
      w2_en_ff     <= w2_en_in;
      w2_cnt_ff    <= w2_cnt_in;
      w2_addr_ff   <= w2_addr_in;
      w2_val_ff    <= w2_val_in;
      w2_old_ff    <= w2_old_in;
      after_ff     <= after_in;
      rsp_fish_ff  <= rsp_fish_in;
      rsp_shark_ff <= rsp_shark_in;
      rsp_site_ff  <= rsp_site_in;
   end

   a_tally_bound: assert property (@(posedge clock) disable iff (reset)
      (17'(fish_ff) + 17'(shark_ff)) <= 17'(CELLS))
      else $error("fish and shark tallies exceed the grid");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_req.we |-> (state_ff == ST_CLEAR || state_ff == ST_WR1 || state_ff == ST_WR2))
      else $error("grid write outside clear or write-back");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_ready)
      else $error("transaction accepted during grid clear");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside done state");

endmodule

`default_nettype wire

/* sim/tb.sv */
// tb: self-checking bench for lattice_predator_prey_update; checks its req/rsp channels and drives its csr port
// depends on lpp_pkg and the block's rtl; keeps its own copy of the torus, the counts and the chances
`timescale 1ns / 1ps

module tb;
   import lpp_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int PHASE_ITEMS = 60;

   typedef struct {
      logic [1:0]        mode;
      logic [SIDE_W-1:0] row;
      logic [SIDE_W-1:0] col;
      logic [1:0]        dir;
      logic [DRAW_W-1:0] pick;
      logic [DRAW_W-1:0] draw;
   } lattice_event_type;

   typedef struct {
      logic [TALLY_W-1:0] fish;
      logic [TALLY_W-1:0] shark;
      logic [CELL_W-1:0]  site;
   } lattice_outcome_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_mode = '0;
   logic [SIDE_W-1:0]     req_site_row = '0;
   logic [SIDE_W-1:0]     req_site_col = '0;
   logic [1:0]            req_direction = '0;
   logic [DRAW_W-1:0]     req_pick_draw = '0;
   logic [DRAW_W-1:0]     req_chance_draw = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [TALLY_W-1:0]    rsp_fish_total;
   logic [TALLY_W-1:0]    rsp_shark_total;
   logic [CELL_W-1:0]     rsp_site_after;

   lattice_event_type   event_queue[$];
   lattice_outcome_type outcome_queue[$];
   cell_type            grid_copy [CELLS];
   int                  fish_count = 0;
   int                  shark_count = 0;
   logic [CHANCE_W-1:0] chance_reg [5];
   int                  row_step [4] = '{1, 0, -1, 0};
   int                  col_step [4] = '{0, 1, 0, -1};
   int                  error_count = 0;
   bit                  req_fire = 1'b0;
   bit                  idle_on = 1'b0;
   int                  send_gap = 0;
   int                  stall_left = 0;

   lattice_predator_prey_update uut (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_site_row    (req_site_row),
      .req_site_col    (req_site_col),
      .req_direction   (req_direction),
      .req_pick_draw   (req_pick_draw),
      .req_chance_draw (req_chance_draw),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_fish_total  (rsp_fish_total),
      .rsp_shark_total (rsp_shark_total),
      .rsp_site_after  (rsp_site_after)
   );

   always #6 clock = ~clock;

   function automatic int cell_at(int row, int col, int dir);
      int r;
      int c;
      r = (row + row_step[dir] + GRID_SIDE) % GRID_SIDE;
      c = (col + col_step[dir] + GRID_SIDE) % GRID_SIDE;
      return r * GRID_SIDE + c;
   endfunction

   function automatic void set_cell(int idx, cell_type v);
      if (grid_copy[idx] == CELL_FISH) fish_count--;
      else if (grid_copy[idx] == CELL_SHARK) shark_count--;
      if (v == CELL_FISH) fish_count++;
      else if (v == CELL_SHARK) shark_count++;
      grid_copy[idx] = v;
   endfunction

   function automatic void play_event(input lattice_event_type ev,
                                      output lattice_outcome_type res);
      int       site;
      int       nb;
      int       count;
      int       sel;
      int       k;
      int       n;
      int       prey [4];
      cell_type held;
      site = int'(ev.row) * GRID_SIDE + int'(ev.col);
      nb = cell_at(int'(ev.row), int'(ev.col), int'(ev.dir));
      case (ev.mode)
         MODE_SEED: begin
            if (ev.draw < chance_reg[REG_SEED_FISH]) set_cell(site, CELL_FISH);
            else if (ev.draw >= chance_reg[REG_SEED_SHARK]) set_cell(site, CELL_SHARK);
            else set_cell(site, CELL_EMPTY);
         end
         MODE_UPDATE: begin
            if (grid_copy[site] == CELL_FISH) begin
               if (grid_copy[nb] == CELL_EMPTY && ev.draw < chance_reg[REG_FISH_BIRTH])
                  set_cell(nb, CELL_FISH);
            end else if (grid_copy[site] == CELL_SHARK) begin
               count = 0;
               for (k = 0; k < 4; k++) begin
                  n = cell_at(int'(ev.row), int'(ev.col), k);
                  if (grid_copy[n] == CELL_FISH) begin
                     prey[count] = n;
                     count++;
                  end
               end
               if (count > 0) begin
                  sel = (count * int'(ev.pick)) >> 16;
                  if (sel >= count) sel = count - 1;
                  set_cell(prey[sel], CELL_SHARK);
                  if (ev.draw >= chance_reg[REG_SHARK_STAY]) set_cell(site, CELL_EMPTY);
               end else if (ev.draw < chance_reg[REG_SHARK_STARVE]) begin
                  set_cell(site, CELL_EMPTY);
               end
            end
         end
         MODE_SWAP: begin
            held = grid_copy[site];
            grid_copy[site] = grid_copy[nb];
            grid_copy[nb] = held;
         end
         default: ;
      endcase
      res.fish = TALLY_W'(fish_count);
      res.shark = TALLY_W'(shark_count);
      res.site = grid_copy[site];
   endfunction

   function automatic void add_event(logic [1:0] mode, int row, int col, int dir,
                                     int pick, int draw);
      lattice_event_type ev;
      ev.mode = mode;
      ev.row = SIDE_W'(row);
      ev.col = SIDE_W'(col);
      ev.dir = 2'(dir);
      ev.pick = DRAW_W'(pick);
      ev.draw = DRAW_W'(draw);
      event_queue.push_back(ev);
   endfunction

   function automatic void check_field(string label, logic [TALLY_W-1:0] want,
                                       logic [TALLY_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         error_count++;
      end
   endfunction

   // most events land in a small window across the wrap so that cells interact
   function automatic void add_random_events(int count);
      int         k;
      int         roll;
      logic [1:0] mode;
      for (k = 0; k < count; k++) begin
         roll = $urandom_range(0, 99);
         if (roll >= 95) begin
            add_event(2'($urandom_range(0, 3)), $urandom_range(0, 127), $urandom_range(0, 127),
                      $urandom_range(0, 3), $urandom_range(0, 65535), $urandom_range(0, 65535));
         end else begin
            if (roll < 30) mode = MODE_SEED;
            else if (roll < 75) mode = MODE_UPDATE;
            else if (roll < 90) mode = MODE_SWAP;
            else mode = MODE_UNUSED;
            add_event(mode, (126 + $urandom_range(0, 5)) % 128, (126 + $urandom_range(0, 5)) % 128,
                      $urandom_range(0, 3), $urandom_range(0, 65535), $urandom_range(0, 65535));
         end
      end
   endfunction

   task automatic wait_drained();
      while (event_queue.size() != 0 || req_valid || outcome_queue.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_register(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      chance_reg[idx] = value[CHANCE_W-1:0];
   endtask

   task automatic load_chances(logic [CSR_DATA_W-1:0] birth, logic [CSR_DATA_W-1:0] stay,
                               logic [CSR_DATA_W-1:0] starve, logic [CSR_DATA_W-1:0] fish_lim,
                               logic [CSR_DATA_W-1:0] shark_floor);
      wait_drained();
      write_register(REG_FISH_BIRTH, birth);
      write_register(REG_SHARK_STAY, stay);
      write_register(REG_SHARK_STARVE, starve);
      write_register(REG_SEED_FISH, fish_lim);
      write_register(REG_SEED_SHARK, shark_floor);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // stimulus and phase control
   initial begin
      int k;
      for (k = 0; k < CELLS; k++) grid_copy[k] = CELL_EMPTY;
      chance_reg[REG_FISH_BIRTH] = 17'd32768;
      chance_reg[REG_SHARK_STAY] = 17'd3277;
      chance_reg[REG_SHARK_STARVE] = 17'd62259;
      chance_reg[REG_SEED_FISH] = 17'd26214;
      chance_reg[REG_SEED_SHARK] = 17'd58982;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed events under the reset chances
      idle_on = 1'b1;
      add_event(MODE_SEED, 0, 0, 0, 0, 65535);
      add_event(MODE_SEED, 1, 0, 1, 65535, 0);
      add_event(MODE_SEED, 127, 0, 2, 0, 26213);
      add_event(MODE_SEED, 0, 127, 3, 0, 1000);
      add_event(MODE_SEED, 0, 1, 0, 0, 26214);
      add_event(MODE_SEED, 127, 127, 0, 0, 58981);
      add_event(MODE_SEED, 127, 127, 0, 0, 58982);
      add_event(MODE_UPDATE, 0, 0, 0, 65535, 65535);
      add_event(MODE_UPDATE, 0, 127, 0, 0, 0);
      add_event(MODE_UPDATE, 1, 0, 0, 0, 0);
      add_event(MODE_UPDATE, 1, 0, 0, 0, 0);
      add_event(MODE_UPDATE, 127, 0, 1, 0, 65535);
      add_event(MODE_UPDATE, 5, 5, 2, 0, 0);
      add_event(MODE_SWAP, 1, 0, 2, 0, 0);
      add_event(MODE_SWAP, 50, 50, 1, 0, 0);
      add_event(MODE_UNUSED, 0, 0, 3, 65535, 65535);
      add_event(MODE_UPDATE, 127, 127, 0, 0, 0);
      add_event(MODE_UPDATE, 127, 127, 0, 0, 65535);
      add_event(MODE_SEED, 1, 0, 0, 0, 65535);
      add_event(MODE_UPDATE, 1, 0, 0, 32768, 3276);
      add_random_events(PHASE_ITEMS);

      load_chances(0, 0, 0, 0, 0);
      add_random_events(PHASE_ITEMS);
      load_chances(65536, 65536, 65536, 65536, 65536);
      add_random_events(PHASE_ITEMS);
      // several thresholds past one, upper data bits ignored
      load_chances(32'hFFFF_FFFF, 70000, 0, 20000, 90000);
      idle_on = 1'b0;
      add_random_events(PHASE_ITEMS);
      load_chances(40000, 30000, 20000, 30000, 45000);
      idle_on = 1'b1;
      add_random_events(PHASE_ITEMS);
      load_chances($urandom_range(0, 65536), $urandom_range(0, 65536), $urandom_range(0, 65536),
                   $urandom_range(0, 65536), $urandom_range(0, 65536));
      add_random_events(PHASE_ITEMS);
      load_chances($urandom_range(0, 65536), $urandom_range(0, 65536), $urandom_range(0, 65536),
                   $urandom_range(0, 65536), $urandom_range(0, 65536));
      add_random_events(PHASE_ITEMS);
      load_chances(32768, 3277, 62259, 26214, 58982);
      idle_on = 1'b0;
      add_random_events(PHASE_ITEMS);
      load_chances($urandom_range(0, 65536), $urandom_range(0, 65536), $urandom_range(0, 65536),
                   $urandom_range(0, 65536), $urandom_range(0, 65536));
      add_random_events(PHASE_ITEMS);

      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("Simulation FAILED");
      $finish;
   end

   // request driver
   always @(negedge clock) begin
      lattice_event_type ev;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (event_queue.size() > 0) begin
            ev = event_queue.pop_front();
            req_valid <= 1'b1;
            req_mode <= ev.mode;
            req_site_row <= ev.row;
            req_site_col <= ev.col;
            req_direction <= ev.dir;
            req_pick_draw <= ev.pick;
            req_chance_draw <= ev.draw;
            if (idle_on && $urandom_range(0, 2) == 0) send_gap = $urandom_range(1, 3);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor: check results first, then predict the transaction taken at this edge
   always @(posedge clock) begin
      lattice_event_type   ev;
      lattice_outcome_type want;
      if (reset) begin
         req_fire = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (outcome_queue.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, actual fish %0d shark %0d site %0d",
                        $time, rsp_fish_total, rsp_shark_total, rsp_site_after);
               error_count++;
            end else begin
               want = outcome_queue.pop_front();
               check_field("fish_total", want.fish, rsp_fish_total);
               check_field("shark_total", want.shark, rsp_shark_total);
               check_field("site_after", TALLY_W'(want.site), TALLY_W'(rsp_site_after));
            end
         end
         req_fire = req_valid && req_ready;
         if (req_fire) begin
            ev.mode = req_mode;
            ev.row = req_site_row;
            ev.col = req_site_col;
            ev.dir = req_direction;
            ev.pick = req_pick_draw;
            ev.draw = req_chance_draw;
            play_event(ev, want);
            outcome_queue.push_back(want);
         end
      end
   end

endmodule
